[rtl/box_blur_3x3_edge_average_core_macros.svh]
// ------------------------------------------------------------------------
// box blur assertion macros
// shared concurrent assertion forms for the blur checker
// ------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_AVERAGE_CORE_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AVERAGE_CORE_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define BBE_ASSERT_CLK(label, clk_sig, rst_n, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define BBE_ASSERT_ALWAYS(label, clk_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

[rtl/bbe_pkg.sv]
// ------------------------------------------------------------------------
// box blur package
// shared constants and types of the 3x3 box blur core
// ------------------------------------------------------------------------
package bbe_pkg;

	// default line store depth
	localparam int MAX_WIDTH_DEF = 1024;

	// register reset values
	localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;

	// register index codes
	localparam logic CFG_FRAME_WIDTH  = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	// input operation codes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// depth of the output queue, also the credit limit
	localparam int FIFO_DEPTH = 8;

	// which neighbors of the output pixel lie inside the frame
	typedef struct packed {
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
	} mask_t;

endpackage

[rtl/bbe_if.sv]
// ------------------------------------------------------------------------
// box blur stream interfaces
// valid/ready channels for input pixels and blurred results
// ------------------------------------------------------------------------
interface bbe_pix_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, operation, red, green, blue, input ready);
	modport sink   (input valid, operation, red, green, blue, output ready);
endinterface

interface bbe_blur_if;
	logic       valid;
	logic       ready;
	logic [7:0] blurred_red;
	logic [7:0] blurred_green;
	logic [7:0] blurred_blue;
	logic       last_of_frame;

	modport source (output valid, blurred_red, blurred_green, blurred_blue, last_of_frame,
		input ready);
	modport sink   (input valid, blurred_red, blurred_green, blurred_blue, last_of_frame,
		output ready);
endinterface

[rtl/bbe_ram.sv]
// ------------------------------------------------------------------------
// box blur generic ram
// one write port, one read port with registered read data
// ------------------------------------------------------------------------
module bbe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/bbe_lane.sv]
// ------------------------------------------------------------------------
// box blur channel lane
// masked 3x3 sum of one color channel and rounded division by the count
// ------------------------------------------------------------------------
module bbe_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  bbe_pkg::mask_t    mask,
	input  logic [8:0][7:0]   px,
	output logic              out_valid,
	output logic [7:0]        result
);

	localparam int          FRAC   = 17;
	localparam logic [17:0] RECIP1 = 18'd131072;
	localparam logic [17:0] RECIP3 = 18'd43691;
	localparam logic [17:0] RECIP9 = 18'd14564;

	logic [11:0] sum_c;
	logic [1:0]  rows_c;
	logic [1:0]  cols_c;
	logic        valid_s3;
	logic [11:0] sum_s3;
	logic [1:0]  rows_s3;
	logic [1:0]  cols_s3;
	logic [3:0]  cnt_c;
	logic [12:0] num_c;
	logic [11:0] quot_c;
	logic [17:0] recip_c;
	logic        valid_s4;
	logic [29:0] prod_s4;

	// masked neighborhood sum
	always_comb begin
		sum_c = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if ((r != 0 || mask.top_ok) && (r != 2 || mask.bot_ok) &&
				    (c != 0 || mask.left_ok) && (c != 2 || mask.right_ok)) begin
					sum_c = sum_c + 12'(px[r * 3 + c]);
				end
			end
		end
		rows_c = 2'd1 + 2'(mask.top_ok) + 2'(mask.bot_ok);
		cols_c = 2'd1 + 2'(mask.left_ok) + 2'(mask.right_ok);
	end

	// sum stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sum_s3  <= sum_c;
		rows_s3 <= rows_c;
		cols_s3 <= cols_c;
	end

	// (2*sum+cnt) div (2*cnt): power-of-two shift, then reciprocal of 1, 3 or 9
	always_comb begin
		cnt_c = 4'(rows_s3) * 4'(cols_s3);
		num_c = {sum_s3, 1'b0} + 13'(cnt_c);
		case (cnt_c)
			4'd2: begin
				quot_c  = 12'(num_c >> 2);
				recip_c = RECIP1;
			end
			4'd3: begin
				quot_c  = 12'(num_c >> 1);
				recip_c = RECIP3;
			end
			4'd4: begin
				quot_c  = 12'(num_c >> 3);
				recip_c = RECIP1;
			end
			4'd6: begin
				quot_c  = 12'(num_c >> 2);
				recip_c = RECIP3;
			end
			4'd9: begin
				quot_c  = 12'(num_c >> 1);
				recip_c = RECIP9;
			end
			default: begin
				quot_c  = 12'(num_c >> 1);
				recip_c = RECIP1;
			end
		endcase
	end

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s4 <= 30'(quot_c) * 30'(recip_c);
	end

	assign out_valid = valid_s4;
	assign result    = prod_s4[FRAC +: 8];

endmodule

[rtl/bbe_merge.sv]
// ------------------------------------------------------------------------
// box blur merge stage
// joins the three lane results into one output beat and queues it
// ------------------------------------------------------------------------
module bbe_merge #(
	parameter int DEPTH = bbe_pkg::FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  logic              last,
	bbe_blur_if.source        blur
);

	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} entry_t;

	entry_t           fifo_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CNW-1:0]   cnt_q;
	logic             pop;

	assign pop = blur.valid && blur.ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= '{red: red, green: green, blue: blue, last: last};
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			cnt_q <= cnt_q + CNW'(push) - CNW'(pop);
		end
	end

	// output beat
	assign blur.valid         = (cnt_q != '0);
	assign blur.blurred_red   = fifo_q[rp_q].red;
	assign blur.blurred_green = fifo_q[rp_q].green;
	assign blur.blurred_blue  = fifo_q[rp_q].blue;
	assign blur.last_of_frame = fifo_q[rp_q].last;

endmodule

[rtl/box_blur_3x3_edge_average_core.sv]
// ------------------------------------------------------------------------
// 3x3 box blur core
// raster-order rgb blur, mean over the in-frame neighbors of each pixel
// ------------------------------------------------------------------------
// usage:
//   pix channel takes one beat per pixel (operation pixel) or a drain tick
//   (operation drain) that flushes one owed output after the frame's end.
//   blur channel gives one beat per output pixel, last_of_frame on the
//   bottom-right pixel. outputs lag the stream by frame_width+1 pixels.
//   apb port sets frame_width (addr 0) and frame_height (addr 4); write
//   only while the block is idle.
// timing:
//   a pixel beat is taken every cycle while ready is high; a drain tick holds
//   ready low while up to three columns are pushed from the line stores.
//   a beat passes from the beat that causes it to the blur port through the
//   issue register, window update, lane sum, lane multiply and output queue.
//   an 8-entry output queue with credit count absorbs receiver stalls: pix
//   ready drops once 8 results are owed and not yet taken.
// reset:
//   counters, window and queue clear at once; line stores are not cleared,
//   no clearing pass is run.
// ------------------------------------------------------------------------
module box_blur_3x3_edge_average_core #(
	parameter int MAX_WIDTH = bbe_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bbe_pix_if.sink     pix,
	bbe_blur_if.source  blur,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int PW  = $clog2(MAX_WIDTH + 2);
	localparam int XW  = ($clog2(MAX_WIDTH + 2) > 13) ? $clog2(MAX_WIDTH + 2) : 13;
	localparam int CRW = $clog2(bbe_pkg::FIFO_DEPTH + 1);

	typedef struct packed {
		bbe_pkg::mask_t mask;
		logic           last;
	} pos_t;

	typedef struct packed {
		logic          v;
		logic          wr;
		logic          zero;
		logic          emit;
		pos_t          pos;
		logic [CW-1:0] addr;
		logic [23:0]   px;
	} op_t;

	// output position of an emit made at stream position (r, c), c up to w
	function automatic pos_t out_pos(input logic [XW-1:0] r, input logic [XW-1:0] c,
		input logic [XW-1:0] w, input logic [XW-1:0] h);
		logic [XW-1:0] oc;
		logic [XW-1:0] orow;
		logic [XW-1:0] k;
		logic [XW:0]   t;
		pos_t          p;
		oc = (c == '0) ? w - XW'(1) : c - XW'(1);
		k  = (c == '0) ? XW'(2) : XW'(1);
		t  = {1'b0, r} - {1'b0, k};
		if (t[XW]) begin
			t = t + {1'b0, h};
		end
		if (t[XW]) begin
			t = t + {1'b0, h};
		end
		orow            = t[XW-1:0];
		p.mask.top_ok   = (orow != '0);
		p.mask.bot_ok   = (orow + XW'(1) < h);
		p.mask.left_ok  = (oc != '0);
		p.mask.right_ok = (oc + XW'(1) < w);
		p.last          = (orow + XW'(1) == h) && (oc + XW'(1) == w);
		return p;
	endfunction

	logic [10:0]      fw_q;
	logic [11:0]      fh_q;
	logic [CW-1:0]    col_q;
	logic [11:0]      row_q;
	logic [PW-1:0]    pend_q;
	logic [PW-1:0]    dcol_q;
	logic             drain_q;
	logic             seq_busy_q;
	logic [XW-1:0]    seq_vc_q;
	logic [XW-1:0]    seq_end_q;
	pos_t             seq_pos_q;
	logic [CRW-1:0]   credit_q;

	logic [XW-1:0]    w_x;
	logic [XW-1:0]    h_x;
	logic [XW-1:0]    c_x;
	logic [XW-1:0]    r_x;
	logic [XW-1:0]    p_x;
	logic [XW-1:0]    target_x;
	logic [XW-1:0]    vs_x;
	logic [XW-1:0]    first_x;
	logic [XW-1:0]    base_x;
	logic [XW-1:0]    cn_x;
	logic [XW-1:0]    rn_x;
	logic             drain_ok;
	logic             accept;
	logic             is_pix;
	logic             cfg_wr;

	op_t              op_c;
	op_t              op_s1;
	logic [23:0]      rd_up;
	logic [23:0]      rd_mid;
	logic [23:0]      col_up;
	logic [23:0]      col_mid;
	logic             byp_v_q;
	logic [CW-1:0]    byp_addr_q;
	logic [23:0]      byp_up_q;
	logic [23:0]      byp_mid_q;
	logic [23:0]      win_q [3][3];
	logic             emit_s2;
	pos_t             pos_s2;
	logic             last_s3;
	logic             last_s4;
	logic [2:0]       lane_v;
	logic [7:0]       lane_res [3];

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= bbe_pkg::FRAME_WIDTH_RST;
			fh_q <= bbe_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				bbe_pkg::CFG_FRAME_WIDTH:  fw_q <= pwdata[10:0];
				bbe_pkg::CFG_FRAME_HEIGHT: fh_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			bbe_pkg::CFG_FRAME_WIDTH:  prdata = {21'd0, fw_q};
			bbe_pkg::CFG_FRAME_HEIGHT: prdata = {20'd0, fh_q};
			default:                   prdata = '0;
		endcase
	end

	// effective frame size and wrapped stream position
	always_comb begin
		if (fw_q == 11'd0) begin
			w_x = XW'(1);
		end else if (XW'(fw_q) > XW'(MAX_WIDTH)) begin
			w_x = XW'(MAX_WIDTH);
		end else begin
			w_x = XW'(fw_q);
		end
		h_x = (fh_q == 12'd0) ? XW'(1) : XW'(fh_q);
		c_x = XW'(col_q);
		r_x = XW'(row_q);
		if (c_x >= w_x) begin
			c_x = '0;
			r_x = r_x + XW'(1);
		end
		if (r_x >= h_x) begin
			r_x = '0;
		end
		p_x = XW'(pend_q);
		if (p_x > w_x + XW'(1)) begin
			p_x = w_x + XW'(1);
		end
		// drain column range, only the last three pushes reach the window
		target_x = w_x + XW'(1) - p_x;
		vs_x     = (XW'(dcol_q) < target_x) ? XW'(dcol_q) : target_x;
		first_x  = (target_x >= vs_x + XW'(2)) ? target_x - XW'(2) : vs_x;
		drain_ok = (p_x != '0) && (r_x == '0) && (c_x == '0);
		// pixel bookkeeping
		base_x = drain_q ? '0 : p_x;
		cn_x   = c_x + XW'(1);
		rn_x   = r_x + XW'(1);
	end

	assign is_pix    = (pix.operation == bbe_pkg::OP_PIXEL);
	assign pix.ready = !seq_busy_q && (credit_q < CRW'(bbe_pkg::FIFO_DEPTH));
	assign accept    = pix.valid && pix.ready;

	// column push issue: drain sequencer first, else an accepted pixel
	always_comb begin
		op_c = '0;
		if (seq_busy_q) begin
			op_c.v    = 1'b1;
			op_c.zero = (seq_vc_q >= w_x);
			op_c.emit = (seq_vc_q == seq_end_q);
			op_c.pos  = seq_pos_q;
			op_c.addr = seq_vc_q[CW-1:0];
		end else if (accept && is_pix) begin
			op_c.v    = 1'b1;
			op_c.wr   = 1'b1;
			op_c.emit = !drain_q && (p_x >= w_x + XW'(1));
			op_c.pos  = out_pos(r_x, c_x, w_x, h_x);
			op_c.addr = c_x[CW-1:0];
			op_c.px   = {pix.red, pix.green, pix.blue};
		end
	end

	// stream position, owed outputs and drain sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			pend_q     <= '0;
			dcol_q     <= '0;
			drain_q    <= 1'b0;
			seq_busy_q <= 1'b0;
			seq_vc_q   <= '0;
			seq_end_q  <= '0;
			seq_pos_q  <= '0;
		end else if (seq_busy_q) begin
			seq_vc_q <= seq_vc_q + XW'(1);
			if (seq_vc_q == seq_end_q) begin
				seq_busy_q <= 1'b0;
			end
		end else if (accept) begin
			if (is_pix) begin
				pend_q  <= (base_x >= w_x + XW'(1)) ? PW'(base_x) : PW'(base_x + XW'(1));
				drain_q <= 1'b0;
				dcol_q  <= '0;
				if (cn_x >= w_x) begin
					col_q <= '0;
					row_q <= (rn_x >= h_x) ? '0 : rn_x[11:0];
				end else begin
					col_q <= cn_x[CW-1:0];
					row_q <= r_x[11:0];
				end
			end else begin
				col_q <= c_x[CW-1:0];
				row_q <= r_x[11:0];
				if (drain_ok) begin
					pend_q     <= PW'(p_x - XW'(1));
					seq_busy_q <= 1'b1;
					seq_vc_q   <= first_x;
					seq_end_q  <= target_x;
					seq_pos_q  <= out_pos('0, target_x, w_x, h_x);
					if (p_x == XW'(1)) begin
						drain_q <= 1'b0;
						dcol_q  <= '0;
					end else begin
						drain_q <= 1'b1;
						dcol_q  <= PW'(target_x + XW'(1));
					end
				end else begin
					pend_q <= PW'(p_x);
				end
			end
		end
	end

	// results owed but not yet taken at the blur port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CRW'(op_c.v && op_c.emit) - CRW'(blur.valid && blur.ready);
		end
	end

	// issue register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op_c;
		end
	end

	// line stores
	bbe_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_ram_upper (
		.clk     (clk),
		.wr_en   (op_s1.v && op_s1.wr),
		.wr_addr (op_s1.addr),
		.wr_data (col_mid),
		.rd_en   (op_c.v),
		.rd_addr (op_c.addr),
		.rd_data (rd_up)
	);

	bbe_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_ram_middle (
		.clk     (clk),
		.wr_en   (op_s1.v && op_s1.wr),
		.wr_addr (op_s1.addr),
		.wr_data (op_s1.px),
		.rd_en   (op_c.v),
		.rd_addr (op_c.addr),
		.rd_data (rd_mid)
	);

	// column data with forwarding of the write made at the read edge
	always_comb begin
		if (byp_v_q && (byp_addr_q == op_s1.addr)) begin
			col_up  = byp_up_q;
			col_mid = byp_mid_q;
		end else begin
			col_up  = rd_up;
			col_mid = rd_mid;
		end
		if (op_s1.zero) begin
			col_up  = '0;
			col_mid = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_v_q <= 1'b0;
		end else begin
			byp_v_q <= op_s1.v && op_s1.wr;
		end
	end

	always_ff @(posedge clk) begin
		byp_addr_q <= op_s1.addr;
		byp_up_q   <= col_mid;
		byp_mid_q  <= op_s1.px;
	end

	// 3x3 window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (op_s1.v) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= col_up;
			win_q[1][2] <= col_mid;
			win_q[2][2] <= op_s1.px;
		end
	end

	// emit flag toward the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
		end else begin
			emit_s2 <= op_s1.v && op_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		pos_s2  <= op_s1.pos;
		last_s3 <= pos_s2.last;
		last_s4 <= last_s3;
	end

	// one lane per color channel
	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		logic [8:0][7:0] lane_px;

		always_comb begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					lane_px[r * 3 + c] = win_q[r][c][23 - 8 * ch -: 8];
				end
			end
		end

		bbe_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (emit_s2),
			.mask      (pos_s2.mask),
			.px        (lane_px),
			.out_valid (lane_v[ch]),
			.result    (lane_res[ch])
		);
	end

	// merge lanes into the output queue
	bbe_merge #(.DEPTH(bbe_pkg::FIFO_DEPTH)) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (lane_v[0] && lane_v[1] && lane_v[2]),
		.red    (lane_res[0]),
		.green  (lane_res[1]),
		.blue   (lane_res[2]),
		.last   (last_s4),
		.blur   (blur)
	);

endmodule

[rtl/bbe_checker.sv]
// ------------------------------------------------------------------------
// box blur port checker
// port-level assertions on the blur core, bound to the top level
// ------------------------------------------------------------------------
`include "box_blur_3x3_edge_average_core_macros.svh"

module bbe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	// a stalled output beat stays offered
	`BBE_ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "blur beat dropped while stalled")

	// the configuration port never waits
	`BBE_ASSERT_ALWAYS(a_pready, clk, pready, "pready low")

	// width readback right after a write
	`BBE_ASSERT_CLK(a_width_rb, clk, arst_n, psel && penable && pwrite && (paddr[2] == bbe_pkg::CFG_FRAME_WIDTH) |=> !psel || pwrite || (paddr[2] != bbe_pkg::CFG_FRAME_WIDTH) || (prdata[10:0] == $past(pwdata[10:0])), "frame_width readback mismatch")

	// height readback right after a write
	`BBE_ASSERT_CLK(a_height_rb, clk, arst_n, psel && penable && pwrite && (paddr[2] == bbe_pkg::CFG_FRAME_HEIGHT) |=> !psel || pwrite || (paddr[2] != bbe_pkg::CFG_FRAME_HEIGHT) || (prdata[11:0] == $past(pwdata[11:0])), "frame_height readback mismatch")

endmodule

bind box_blur_3x3_edge_average_core bbe_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (blur.valid),
	.out_ready (blur.ready),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata),
	.pready    (pready)
);
